[rtl/lswp_pkg.sv]
// shared constants for the led symbol word packer
package lswp_pkg;

   // frame geometry
   localparam int FRAME_WORDS = 64;
   localparam int MAX_BYTES   = 86;

   // counters must hold their limits themselves
   localparam int WORDS_W = $clog2(FRAME_WORDS + 1);
   localparam int BYTES_W = $clog2(MAX_BYTES + 1);

   localparam logic [WORDS_W-1:0] WORDS_FULL = WORDS_W'(FRAME_WORDS);
   localparam logic [WORDS_W-1:0] WORDS_LAST = WORDS_W'(FRAME_WORDS - 1);
   localparam logic [BYTES_W-1:0] BYTES_FULL = BYTES_W'(MAX_BYTES);

   // pulse symbols
   localparam logic [2:0] SYM_ONE  = 3'b110;
   localparam logic [2:0] SYM_ZERO = 3'b100;
   localparam logic [2:0] SYM_NONE = 3'b000;

   // eleven symbols per word, slots 0..10
   localparam logic [3:0] SLOT_LAST = 4'd10;

   // bit position within the color byte
   localparam logic [2:0] BIT_LAST = 3'd7;

endpackage

[rtl/led_symbol_word_packer.sv]
// top level: expands color bytes into 3-bit pulse symbols packed into 32-bit words
// one symbol enters the word shift register per cycle unless the eleventh waits on a stalled output: a byte holds
// the input through accept, its eight symbols and a wrap-up step, longer when the output stalls
// a word is presented on rsp the cycle after its eleventh symbol is shifted in
// the last byte flushes a partial word with zero symbols, then one zero padding word per cycle while the output is free
// synchronous active-high reset clears the frame counters, the word and the output valid flag
module led_symbol_word_packer
   import lswp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // word output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_packed_word,
   output logic        rsp_frame_end
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a byte
   localparam logic [2:0] ST_SYM   = 3'd1;  // one symbol per cycle, the eleventh waits for a free output
   localparam logic [2:0] ST_TAIL  = 3'd2;  // decide on end of frame
   localparam logic [2:0] ST_FLUSH = 3'd3;  // shift zero symbols to align a partial word
   localparam logic [2:0] ST_PAD   = 3'd4;  // zero words up to the frame length

   logic [2:0]         state_ff,       state_in;
   logic [7:0]         byte_sr_ff,     byte_sr_in;   // color byte, msb shifts out first
   logic [2:0]         bit_cnt_ff,     bit_cnt_in;
   logic               last_ff,        last_in;
   logic [31:0]        acc_ff,         acc_in;       // word shift register, symbols enter at lsb
   logic [3:0]         slot_ff,        slot_in;
   logic [WORDS_W-1:0] words_sent_ff,  words_sent_in;
   logic [BYTES_W-1:0] bytes_taken_ff, bytes_taken_in;
   logic               rsp_valid_ff,   rsp_valid_in;
   logic [31:0]        rsp_word_ff,    rsp_word_in;
   logic               rsp_end_ff,     rsp_end_in;

   logic        out_free;     // output register can take a word this cycle
   logic [2:0]  sym;          // symbol for the current data bit
   logic        emit_en;
   logic [31:0] emit_word;
   logic        frame_clear;
   logic        bit_step;     // a data bit has been consumed

   always_comb begin
      state_in       = state_ff;
      byte_sr_in     = byte_sr_ff;
      bit_cnt_in     = bit_cnt_ff;
      last_in        = last_ff;
      acc_in         = acc_ff;
      slot_in        = slot_ff;
      words_sent_in  = words_sent_ff;
      bytes_taken_in = bytes_taken_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_word_in    = rsp_word_ff;
      rsp_end_in     = rsp_end_ff;

      out_free    = !rsp_valid_ff || !rsp_stall;
      sym         = byte_sr_ff[7] ? SYM_ONE : SYM_ZERO;
      emit_en     = 1'b0;
      emit_word   = '0;
      frame_clear = 1'b0;
      bit_step    = 1'b0;

      // output register drains when the receiver takes the item
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_sr_in = req_data_byte;
               last_in    = req_last_byte;
               bit_cnt_in = '0;
               // bytes past the frame limit are dropped, their last mark still counts
               if (bytes_taken_ff < BYTES_FULL) begin
                  bytes_taken_in = bytes_taken_ff + 1'b1;
                  state_in       = ST_SYM;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_SYM: begin
            if (words_sent_ff == WORDS_FULL) begin
               // frame already full: remaining bits are discarded
               state_in = ST_TAIL;
            end else if (slot_ff == SLOT_LAST) begin
               // eleventh symbol keeps only its upper two bits
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_word = {acc_ff[29:0], sym[2:1]};
                  bit_step  = 1'b1;
               end
            end else begin
               acc_in   = {acc_ff[28:0], sym};
               slot_in  = slot_ff + 1'b1;
               bit_step = 1'b1;
            end
         end
         ST_TAIL: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (words_sent_ff == WORDS_FULL) begin
               frame_clear = 1'b1;
               state_in    = ST_IDLE;
            end else if (slot_ff != '0) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_FLUSH: begin
            // empty symbols push the partial word up to bit 31
            if (slot_ff == SLOT_LAST) begin
               if (out_free) begin
                  emit_en   = 1'b1;
                  emit_word = {acc_ff[29:0], 2'b00};
                  state_in  = ST_PAD;
               end
            end else begin
               acc_in  = {acc_ff[28:0], SYM_NONE};
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_PAD: begin
            if (words_sent_ff == WORDS_FULL) begin
               frame_clear = 1'b1;
               state_in    = ST_IDLE;
            end else if (out_free) begin
               emit_en   = 1'b1;
               emit_word = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // next data bit of the byte
      if (bit_step) begin
         byte_sr_in = {byte_sr_ff[6:0], 1'b0};
         bit_cnt_in = bit_cnt_ff + 1'b1;
         if (bit_cnt_ff == BIT_LAST) begin
            state_in = ST_TAIL;
         end
      end

      // load a finished word into the output register
      if (emit_en) begin
         rsp_valid_in  = 1'b1;
         rsp_word_in   = emit_word;
         rsp_end_in    = (words_sent_ff == WORDS_LAST);
         words_sent_in = words_sent_ff + 1'b1;
         acc_in        = '0;
         slot_in       = '0;
      end

      // end of frame: start the next one from scratch
      if (frame_clear) begin
         acc_in         = '0;
         slot_in        = '0;
         words_sent_in  = '0;
         bytes_taken_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         acc_ff         <= '0;
         slot_ff        <= '0;
         words_sent_ff  <= '0;
         bytes_taken_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         bit_cnt_ff     <= '0;
         last_ff        <= 1'b0;
      end else begin
         state_ff       <= state_in;
         acc_ff         <= acc_in;
         slot_ff        <= slot_in;
         words_sent_ff  <= words_sent_in;
         bytes_taken_ff <= bytes_taken_in;
         rsp_valid_ff   <= rsp_valid_in;
         bit_cnt_ff     <= bit_cnt_in;
         last_ff        <= last_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      byte_sr_ff  <= byte_sr_in;
      rsp_word_ff <= rsp_word_in;
      rsp_end_ff  <= rsp_end_in;
   end

   // one byte in flight at a time
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_word = rsp_word_ff;
   assign rsp_frame_end   = rsp_end_ff;

endmodule

[rtl/lswp_checker.sv]
// port-level checks for the led symbol word packer, bound to the top level
module lswp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_data_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_packed_word,
   input logic        rsp_frame_end
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_packed_word)
                                 && $stable(rsp_frame_end))
      else $error("stalled word changed");

   // no word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word present after reset");

   // an accepted byte leaves the input busy after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not held busy after a byte");

   // a taken frame-end word is never directly followed by another frame-end word
   a_frame_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_frame_end |=> !(rsp_valid && rsp_frame_end))
      else $error("two frame-end words in a row");

endmodule

bind led_symbol_word_packer lswp_checker u_lswp_checker (.*);

[dv/tb_led_symbol_word_packer.sv]
// testbench for the led symbol word packer: byte frames in, predicted serializer words checked out
module tb_led_symbol_word_packer;
   import lswp_pkg::*;

   localparam int SYMS_PER_WORD = 11;
   localparam int IDLE_PCT      = 32;
   localparam int QUIET_LIMIT   = 2000;   // cycles with no item moving on either side
   localparam int SETTLE_CYCLES = 100;
   localparam int TARGET_BYTES  = 200;    // bytes that the block actually packs
   localparam int CALM_FROM     = 60;     // accepted-byte window with no idling at all
   localparam int CALM_TO       = 110;

   typedef struct {
      logic [7:0] color;
      logic       last_mark;
      bit         drain;      // hold this item back until every word is out
   } color_item_type;

   typedef struct {
      logic [31:0] word;
      logic        frame_end;
   } led_word_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte   = 8'h00;
   logic        req_last_byte   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [31:0] rsp_packed_word;
   logic        rsp_frame_end;

   color_item_type pending_bytes[$];
   led_word_type   expected_words[$];

   // predictor copy of the frame state
   logic [31:0] acc_word;
   int          slot_count;
   int          words_out;
   int          bytes_in;

   int fail_count     = 0;
   int bytes_accepted = 0;
   int words_checked  = 0;
   int items_queued   = 0;
   int packed_queued  = 0;   // queued bytes that fall inside MAX_BYTES of their frame
   int gen_pos        = 0;   // byte position within the frame being generated
   int quiet_cycles   = 0;

   led_symbol_word_packer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_word (rsp_packed_word),
      .rsp_frame_end   (rsp_frame_end)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_frame();
      acc_word   = '0;
      slot_count = 0;
      words_out  = 0;
      bytes_in   = 0;
   endfunction

   function automatic void push_word(logic [31:0] w);
      led_word_type e;
      words_out++;
      e.word      = w;
      e.frame_end = (words_out >= FRAME_WORDS);
      expected_words.push_back(e);
   endfunction

   // expand one color byte msb first, emit full words, flush and pad on the last byte
   function automatic void pack_color_byte(logic [7:0] color, logic last_mark);
      logic [2:0] sym;
      if (bytes_in < MAX_BYTES) begin
         bytes_in++;
         for (int b = 7; b >= 0; b--) begin
            if (words_out >= FRAME_WORDS)
               break;
            sym = color[b] ? SYM_ONE : SYM_ZERO;
            // eleventh symbol keeps only its top two bits, the pad bit falls off
            acc_word |= {sym, 29'b0} >> (slot_count * 3);
            slot_count++;
            if (slot_count == SYMS_PER_WORD) begin
               push_word(acc_word);
               acc_word   = '0;
               slot_count = 0;
            end
         end
      end
      if (last_mark) begin
         if (slot_count != 0 && words_out < FRAME_WORDS)
            push_word(acc_word);
         while (words_out < FRAME_WORDS)
            push_word('0);
         clear_frame();
      end
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic bit idle_now();
      if (bytes_accepted >= CALM_FROM && bytes_accepted < CALM_TO)
         return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   function automatic void queue_byte(logic [7:0] color, logic last_mark, bit drain);
      color_item_type it;
      it.color     = color;
      it.last_mark = last_mark;
      it.drain     = drain;
      pending_bytes.push_back(it);
      items_queued++;
      if (gen_pos < MAX_BYTES)
         packed_queued++;
      gen_pos = last_mark ? 0 : gen_pos + 1;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      fail_count++;
      $display("mismatch %0s on word %0d: got %h want %h", field, words_checked, got, want);
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      color_item_type it;
      if (reset) begin
         clear_frame();
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pack_color_byte(req_data_byte, req_last_byte);
            bytes_accepted++;
         end
         // payload may only change once the current item is gone
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() != 0 && !idle_now() &&
                !(pending_bytes[0].drain && expected_words.size() != 0)) begin
               it = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= it.color;
               req_last_byte <= it.last_mark;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      led_word_type want_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with none pending", rsp_packed_word, '0);
            end else begin
               want_w = expected_words.pop_front();
               if (rsp_packed_word !== want_w.word)
                  report_mismatch("packed_word", rsp_packed_word, want_w.word);
               if (rsp_frame_end !== want_w.frame_end)
                  report_mismatch("frame_end", 32'(rsp_frame_end), 32'(want_w.frame_end));
            end
            words_checked++;
         end
         rsp_stall <= idle_now();
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      int  len;
      int  pick;
      bit  first;

      // single-byte frames at both extremes: partial flush then zero padding
      queue_byte(8'hFF, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0);
      // lone high and low bits
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'h01, 1'b0, 1'b0);
      queue_byte(8'h7F, 1'b0, 1'b0);
      queue_byte(8'hFE, 1'b1, 1'b0);
      // eleven bytes fill exactly eight words: empty flush, padding only
      for (int i = 0; i < 11; i++)
         queue_byte((i % 2) ? 8'h55 : 8'hAA, i == 10, 1'b0);
      queue_byte(8'hA5, 1'b0, 1'b0);
      queue_byte(8'h5A, 1'b1, 1'b0);

      // random frames; the first one overruns MAX_BYTES so excess bytes are dropped
      first = 1'b1;
      while (packed_queued < TARGET_BYTES) begin
         pick = $urandom_range(0, 9);
         if (first || pick == 0)
            len = MAX_BYTES + $urandom_range(1, 6);
         else if (pick == 1)
            len = SYMS_PER_WORD * $urandom_range(1, 7);
         else
            len = $urandom_range(1, 20);
         for (int i = 0; i < len; i++)
            queue_byte(8'($urandom_range(0, 255)), i == len - 1,
                       (i == 0) && (first || $urandom_range(0, 9) == 0));
         first = 1'b0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < items_queued)
         @(posedge clock);
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
